// ===== hw/rtl/udphc_pkg.sv =====
// Shared types and constants for the UDP header checksum builder.
package udphc_pkg;

  localparam int unsigned HDR_SUM_W = 20;

  localparam logic [15:0] HDR_BYTES = 16'd8;
  localparam logic [15:0] UDP_PROTO = 16'd17;
  localparam logic [15:0] CAP_RESET = 16'hFFFF;
  localparam logic [15:0] MASK16    = 16'hFFFF;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_BYTE  = 1'b1
  } kind_t;

  typedef enum logic {
    STATUS_OK       = 1'b0,
    STATUS_TOO_LONG = 1'b1
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] header_word;
    logic [15:0] total_length;
    status_t     status;
  } out_item_t;

  // Registered item handed from the input stage to the checksum stage
  typedef struct packed {
    kind_t                 kind;
    logic                  too_long;
    logic [31:0]           port_pair;
    logic [15:0]           payload_length;
    logic [HDR_SUM_W-1:0]  hdr_sum;
    logic [7:0]            data_byte;
  } stage_item_t;

endpackage

// ===== hw/rtl/udphc_front.sv =====
// Input stage: capacity register, length check and pseudo-header partial sum.
module udphc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  udphc_pkg::in_item_t    in_item,
  input  logic                   advance,
  output logic                   stage_valid,
  output udphc_pkg::stage_item_t stage_item
);
  import udphc_pkg::*;

  logic [15:0]          buffer_capacity;
  logic [16:0]          total_wide;
  logic [15:0]          total16;
  logic [HDR_SUM_W-1:0] sum_next;
  stage_item_t          stage_item_next;

  // Capacity register, to be written only while idle; the user must ensure this, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_capacity <= CAP_RESET;
    end else if (cfg_we) begin
      buffer_capacity <= cfg_wdata;
    end
  end

  // Length check and raw sum of pseudo-header plus UDP header words
  always_comb begin
    total_wide = {1'b0, in_item.payload_length} + {1'b0, HDR_BYTES};
    total16    = total_wide[15:0];
    sum_next   = HDR_SUM_W'(in_item.source_address[31:16])
               + HDR_SUM_W'(in_item.source_address[15:0])
               + HDR_SUM_W'(in_item.dest_address[31:16])
               + HDR_SUM_W'(in_item.dest_address[15:0])
               + HDR_SUM_W'(UDP_PROTO)
               + HDR_SUM_W'(in_item.source_port)
               + HDR_SUM_W'(in_item.dest_port)
               + HDR_SUM_W'(total16)
               + HDR_SUM_W'(total16);
    stage_item_next.kind           = in_item.kind;
    stage_item_next.too_long       = (total_wide > {1'b0, buffer_capacity});
    stage_item_next.port_pair      = {in_item.source_port, in_item.dest_port};
    stage_item_next.payload_length = in_item.payload_length;
    stage_item_next.hdr_sum        = sum_next;
    stage_item_next.data_byte      = in_item.data_byte;
  end

  assign in_ready = !stage_valid || advance;

  // Stage valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= stage_item_next;
    end
  end

endmodule

// ===== hw/rtl/udphc_core.sv =====
// Checksum stage: message state, ones-complement accumulator and result register.
module udphc_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   stage_valid,
  input  udphc_pkg::stage_item_t stage_item,
  output logic                   advance,
  output logic                   out_valid,
  input  logic                   out_ready,
  output udphc_pkg::out_item_t   out_item
);
  import udphc_pkg::*;

  logic        in_message;
  logic [15:0] running_sum;
  logic [15:0] bytes_seen;
  logic [15:0] expected_length;
  logic [31:0] port_pair;

  logic        in_message_next;
  logic [15:0] running_sum_next;
  logic [15:0] bytes_seen_next;
  logic [15:0] expected_length_next;
  logic [31:0] port_pair_next;

  logic        emit;
  out_item_t   out_item_next;

  logic [16:0] fold_a;
  logic [15:0] start_sum;
  logic [15:0] byte_word;
  logic [16:0] byte_add;
  logic [15:0] byte_sum;
  logic [15:0] final_sum;
  logic [15:0] checksum;
  logic [15:0] total16;

  assign advance = stage_valid && (!out_valid || out_ready);

  // Fold header sum and add the next payload byte with end-around carry
  always_comb begin
    fold_a    = {1'b0, stage_item.hdr_sum[15:0]}
              + 17'(stage_item.hdr_sum[HDR_SUM_W-1:16]);
    start_sum = fold_a[15:0] + 16'(fold_a[16]);
    byte_word = bytes_seen[0] ? {8'd0, stage_item.data_byte}
                              : {stage_item.data_byte, 8'd0};
    byte_add  = {1'b0, running_sum} + {1'b0, byte_word};
    byte_sum  = byte_add[15:0] + 16'(byte_add[16]);
  end

  // Next state and result
  always_comb begin
    in_message_next      = in_message;
    running_sum_next     = running_sum;
    bytes_seen_next      = bytes_seen;
    expected_length_next = expected_length;
    port_pair_next       = port_pair;
    emit                 = 1'b0;
    final_sum            = running_sum;
    out_item_next.status = STATUS_OK;

    if (advance) begin
      case (stage_item.kind)
        KIND_START: begin
          in_message_next = 1'b0;
          if (stage_item.too_long) begin
            emit                 = 1'b1;
            out_item_next.status = STATUS_TOO_LONG;
          end else begin
            running_sum_next     = start_sum;
            port_pair_next       = stage_item.port_pair;
            expected_length_next = stage_item.payload_length;
            bytes_seen_next      = 16'd0;
            final_sum            = start_sum;
            if (stage_item.payload_length == 16'd0) begin
              emit = 1'b1;
            end else begin
              in_message_next = 1'b1;
            end
          end
        end
        KIND_BYTE: begin
          if (in_message) begin
            running_sum_next = byte_sum;
            bytes_seen_next  = bytes_seen + 16'd1;
            final_sum        = byte_sum;
            if (bytes_seen_next == expected_length) begin
              emit            = 1'b1;
              in_message_next = 1'b0;
            end
          end
        end
        default: begin
          in_message_next = in_message;
        end
      endcase
    end

    // Complement, with zero sent as all ones
    checksum = ~final_sum;
    if (checksum == 16'd0) begin
      checksum = MASK16;
    end
    total16 = expected_length_next + HDR_BYTES;

    if (out_item_next.status == STATUS_TOO_LONG) begin
      out_item_next.header_word  = 64'd0;
      out_item_next.total_length = 16'd0;
    end else begin
      out_item_next.header_word  = {port_pair_next, total16, checksum};
      out_item_next.total_length = total16;
    end
  end

  // Message state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message      <= 1'b0;
      running_sum     <= 16'd0;
      bytes_seen      <= 16'd0;
      expected_length <= 16'd0;
      port_pair       <= 32'd0;
    end else begin
      in_message      <= in_message_next;
      running_sum     <= running_sum_next;
      bytes_seen      <= bytes_seen_next;
      expected_length <= expected_length_next;
      port_pair       <= port_pair_next;
    end
  end

  // Result valid: set on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= out_item_next;
    end
  end

endmodule

// ===== hw/rtl/udp_header_checksum_builder.sv =====
// Top level of the UDP header builder with IPv4 pseudo-header checksum.
//
// Input channel (in_valid/in_ready/in_item): a start transaction carries the
// addresses, ports and payload length; byte transactions then carry the
// payload, one byte each. Output channel (out_valid/out_ready/out_item): one
// result per completed message, either the finished 8-byte header with its total
// length, or a too-long status if header plus payload exceeds the capacity.
// Configuration: cfg_we/cfg_wdata write the buffer capacity; write it only
// while no message is in flight.
// Result path: the transaction that completes a message (the last payload
// byte, or the start of an empty or oversized message) passes the input
// register and then the checksum stage, which registers the result.
// Throughput: one transaction per cycle while no result waits on out_ready.
// Reset: capacity returns to 65535, no message is open, both channels empty.
// Stall: while a result waits on out_ready, the checksum stage cannot advance;
// the input register then holds its transaction and in_ready drops, so the
// block takes at most one more transaction behind a stalled result.
module udp_header_checksum_builder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  udphc_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output udphc_pkg::out_item_t out_item
);
  import udphc_pkg::*;

  logic        stage_valid;
  logic        advance;
  stage_item_t stage_item;

  udphc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  udphc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

`ifndef ASSERT_OFF
  // Input backpressure only comes from a stalled result
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled result");

  // Too-long results carry no header
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status == STATUS_TOO_LONG) |->
      (out_item.header_word == 64'd0 && out_item.total_length == 16'd0))
    else $error("too-long result with nonzero header");

  // Good results: nonzero checksum and consistent length
  a_ok_header: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status == STATUS_OK) |->
      (out_item.header_word[15:0] != 16'd0 &&
       out_item.header_word[31:16] == out_item.total_length))
    else $error("malformed header in good result");

  // A fresh result never appears without a stage transaction behind it
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(advance))
    else $error("result without a processed transaction");
`endif

endmodule

// ===== bench/tb.sv =====
// Testbench for the UDP header checksum builder: random and directed traffic, scoreboard check.
`timescale 1ns / 100ps

module tb;
  import udphc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int MAX_PRINTED = 100;

  // Predict each header from accepted transactions and match it against the output
  class header_checker;
    logic [15:0] capacity;
    logic [15:0] sum_acc;
    logic [15:0] bytes_taken;
    logic [15:0] msg_length;
    logic [31:0] ports;
    bit          busy;
    out_item_t   expected_headers[$];
    int          errors;

    function new();
      capacity    = CAP_RESET;
      sum_acc     = '0;
      bytes_taken = '0;
      msg_length  = '0;
      ports       = '0;
      busy        = 1'b0;
      errors      = 0;
    endfunction

    // End-around carry add of two 16-bit words
    function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[15:0] + 16'(t[16]);
    endfunction

    // Advance the predicted state by one transaction; return 1 when a result is due
    function bit predict_header(in_item_t it, output out_item_t r);
      logic [16:0] total17;
      logic [15:0] total;
      logic [15:0] ck;
      r = '0;
      if (it.kind == KIND_START) begin
        total17 = {1'b0, it.payload_length} + {1'b0, HDR_BYTES};
        busy = 1'b0;
        if (total17 > {1'b0, capacity}) begin
          r.status = STATUS_TOO_LONG;
          return 1'b1;
        end
        total   = total17[15:0];
        sum_acc = ones_add(16'h0000, it.source_address[31:16]);
        sum_acc = ones_add(sum_acc, it.source_address[15:0]);
        sum_acc = ones_add(sum_acc, it.dest_address[31:16]);
        sum_acc = ones_add(sum_acc, it.dest_address[15:0]);
        sum_acc = ones_add(sum_acc, UDP_PROTO);
        sum_acc = ones_add(sum_acc, total);
        sum_acc = ones_add(sum_acc, it.source_port);
        sum_acc = ones_add(sum_acc, it.dest_port);
        sum_acc = ones_add(sum_acc, total);
        ports       = {it.source_port, it.dest_port};
        msg_length  = it.payload_length;
        bytes_taken = '0;
        if (it.payload_length != 16'd0) begin
          busy = 1'b1;
          return 1'b0;
        end
      end else begin
        // drop payload bytes outside a message
        if (!busy) return 1'b0;
        sum_acc = ones_add(sum_acc, bytes_taken[0] ? {8'h00, it.data_byte}
                                                   : {it.data_byte, 8'h00});
        bytes_taken = bytes_taken + 16'd1;
        if (bytes_taken != msg_length) return 1'b0;
      end
      // finish the header; a zero checksum goes out as all ones
      busy  = 1'b0;
      total = msg_length + HDR_BYTES;
      ck    = ~sum_acc;
      if (ck == 16'h0000) ck = MASK16;
      r.header_word  = {ports, total, ck};
      r.total_length = total;
      r.status       = STATUS_OK;
      return 1'b1;
    endfunction

    // Note an accepted input transaction; return 1 if it did real work
    function bit note_input(in_item_t it);
      out_item_t r;
      bit        took;
      took = (it.kind == KIND_START) || busy;
      if (predict_header(it, r)) expected_headers.push_back(r);
      return took;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_headers.size() == 0) begin
        report("result with nothing pending", got.header_word, 64'd0);
        return;
      end
      want = expected_headers.pop_front();
      if (got.header_word !== want.header_word)
        report("header_word", got.header_word, want.header_word);
      if (got.total_length !== want.total_length)
        report("total_length", 64'(got.total_length), 64'(want.total_length));
      if (got.status !== want.status)
        report("status", 64'(got.status), 64'(want.status));
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  header_checker sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int work_done     = 0;

  udp_header_checksum_builder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Offer one transaction after random idle cycles and hold it until accepted
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (sb.note_input(it)) work_done++;
  endtask

  task automatic send_start(logic [31:0] src, logic [31:0] dst, logic [15:0] sp,
                            logic [15:0] dp, logic [15:0] plen);
    in_item_t it;
    it.kind           = KIND_START;
    it.source_address = src;
    it.dest_address   = dst;
    it.source_port    = sp;
    it.dest_port      = dp;
    it.payload_length = plen;
    it.data_byte      = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_byte(logic [7:0] b);
    in_item_t it;
    it.kind           = KIND_BYTE;
    it.source_address = $urandom;
    it.dest_address   = $urandom;
    it.source_port    = 16'($urandom);
    it.dest_port      = 16'($urandom);
    it.payload_length = 16'($urandom);
    it.data_byte      = b;
    send_item(it);
  endtask

  task automatic send_random_start(logic [15:0] plen);
    send_start($urandom, $urandom, 16'($urandom), 16'($urandom), plen);
  endtask

  // Mostly lengths that fit, some right at the capacity edge, some far too long
  function automatic logic [15:0] pick_length(logic [15:0] cap);
    int r;
    int room;
    int top;
    int v;
    r    = $urandom_range(0, 99);
    room = int'(cap) - 8;
    if (r < 8 || room < 0) begin
      v = $urandom_range(0, 65535);
      if (v <= room && v > 300) v = room + 1 + $urandom_range(0, 65534 - room);
      return 16'(v);
    end
    if (r < 16 && room <= 300) return 16'(room + $urandom_range(0, 1));
    top = (r < 24) ? 300 : 24;
    if (top > room) top = room;
    return 16'($urandom_range(0, top));
  endfunction

  // One message: a start, then its bytes, sometimes cut short
  task automatic send_message();
    logic [15:0] plen;
    int          nbytes;
    bit          fits;
    plen = pick_length(sb.capacity);
    fits = ({1'b0, plen} + 17'd8) <= {1'b0, sb.capacity};
    send_random_start(plen);
    if (!fits) nbytes = $urandom_range(0, 2);
    else if (plen != 0 && $urandom_range(0, 99) < 10) nbytes = $urandom_range(0, plen - 1);
    else nbytes = plen;
    repeat (nbytes) send_byte(8'($urandom));
  endtask

  // Finish any open message so the block goes idle
  task automatic close_message();
    while (sb.busy) send_byte(8'($urandom));
  endtask

  // Drop valid, then wait until every result is out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_headers.size() > 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [15:0] value);
    close_message();
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    sb.capacity = value;
  endtask

  // Output side: check each transaction, stall at random or for a requested stretch
  initial begin
    int hold_left;
    hold_left = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) sb.check_result(out_item);
      if (hold_left == 0 && hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [15:0] caps[6];
    int          targets[6];
    int          phase_base;
    bit          did_hold;
    bit          did_pause;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset capacity
    send_idle_pct = 20;
    recv_idle_pct = 72;
    send_byte(8'hFF);
    send_start(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    send_start(32'h0, 32'h0, 16'h0000, 16'hFFDE, 16'd0);
    send_start(32'hC0A8_0001, 32'h0A00_00FE, 16'h1234, 16'h0035, 16'd3);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hAB);
    send_start(32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h0001, 16'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_start(32'h0102_0304, 32'hFEDC_BA98, 16'hAAAA, 16'h5555, 16'd65527);
    send_byte(8'h5A);
    send_start(32'h7FFF_FFFF, 32'h8000_0000, 16'h0001, 16'h8000, 16'd65528);
    send_start(32'h1111_1111, 32'h2222_2222, 16'h3333, 16'h4444, 16'd65535);
    send_byte(8'h5A);
    send_start(32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'h0F0F, 16'hF0F0, 16'd1);
    send_byte(8'h80);
    send_byte(8'h01);

    // Random phases, each with its own capacity and idling pattern
    caps    = '{16'd8, 16'd0, 16'($urandom_range(9, 300)), 16'($urandom_range(0, 65535)),
                16'hFFFF, 16'($urandom_range(20, 60))};
    targets = '{50, 40, 140, 140, 160, 140};
    did_hold  = 1'b0;
    did_pause = 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 72 : 0;
      recv_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 20 : 0;
      write_capacity(caps[ph]);
      phase_base = work_done;
      while (work_done - phase_base < targets[ph]) begin
        if ($urandom_range(0, 99) < 5) send_byte(8'($urandom));
        else send_message();
        // stall the output for a long stretch while empty messages pile up
        if (ph == 4 && !did_hold && work_done - phase_base >= 30) begin
          hold_req = 80;
          repeat (12) send_random_start(16'd0);
          did_hold = 1'b1;
        end
        // hold the input until every pending header is out
        if (ph == 4 && !did_pause && work_done - phase_base >= 80) begin
          drain_results();
          did_pause = 1'b1;
        end
      end
    end

    close_message();
    drain_results();
    repeat (10) @(posedge clk);
    if (sb.expected_headers.size() > 0)
      sb.report("results never arrived", 64'd0, 64'(sb.expected_headers.size()));
    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
